// File: rtl/adc_event_word_decoder_unit_assert.svh
// ----------------------------------------------------------------------------
// ADC event word decoder assertion macros
// Shared concurrent check forms, clocked on aclk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ADC_EVENT_WORD_DECODER_UNIT_ASSERT_SVH
`define ADC_EVENT_WORD_DECODER_UNIT_ASSERT_SVH

// Condition holds at every edge out of reset.
`define AEWD_CHECK(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define AEWD_CHECK_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define AEWD_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/aewd_pkg.sv
// ----------------------------------------------------------------------------
// aewd_pkg
// Field layout, word type codes, sequencer states and shared adder request.
// ----------------------------------------------------------------------------
package aewd_pkg;

    localparam int WORD_W   = 32;
    localparam int KIND_W   = 3;
    localparam int KIND_LSB = 24;
    localparam int MAG_W    = 12;
    localparam int SIGN_POS = 13;
    localparam int CHAN_LSB = 17;
    localparam int CHAN_W   = 4;
    localparam int VALUE_W  = 13;
    localparam int COUNT_W  = 24;
    localparam int ENTRY_W  = CHAN_W + VALUE_W;
    localparam int TDATA_W  = 48;
    localparam int ALU_W    = VALUE_W;

    typedef logic [KIND_W-1:0] kind_t;

    localparam kind_t KIND_DATA   = 3'd0;
    localparam kind_t KIND_HEADER = 3'd2;
    localparam kind_t KIND_END    = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_BUMP,
        S_READ,
        S_EMIT
    } state_t;

    // Request to the shared adder: result = (invert ? ~operand : operand) + carry
    typedef struct packed {
        logic [ALU_W-1:0] operand;
        logic             invert;
        logic             carry;
    } alu_req_t;

endpackage

// File: rtl/adc_event_word_decoder_unit.sv
// ----------------------------------------------------------------------------
// adc_event_word_decoder_unit - ADC event buffer word decoder
// Steps from transfer to transfer: decode, idle for header, ignored and dropped data words;
// decode, fill advance, idle for a stored data word. End of block: decode, read and emit
// per entry, idle. First entry is on m_tvalid after read and emit; output stalls hold emit.
// One word in flight at a time; the shared adder and the single store read port set the pace.
// Reset: synchronous active-low aresetn empties the buffer count and overflow flag.
// ----------------------------------------------------------------------------
`include "adc_event_word_decoder_unit_assert.svh"

module adc_event_word_decoder_unit
    import aewd_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    // Input word stream
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [WORD_W-1:0]  s_tdata,   // [31:0] word
    // Decoded entry stream
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // [3:0] entry_channel, [16:4] adc_value,
                                          // [40:17] event_count, [47:41] zero
    output logic [0:0]         m_tuser,   // [0] dropped_data
    output logic               m_tlast    // last_entry
);

    // Fill counter must hold MAX_ENTRIES itself; store address covers the entries.
    localparam int FILL_W = $clog2(MAX_ENTRIES + 1);
    localparam int ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t               state_reg,    state_next;
    logic [WORD_W-1:0]    word_reg,     word_next;
    logic [FILL_W-1:0]    fill_reg,     fill_next;
    logic                 overflow_reg, overflow_next;
    logic [FILL_W-1:0]    idx_reg,      idx_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [TDATA_W-1:0]   m_tdata_reg,  m_tdata_next;
    logic                 m_tuser_reg,  m_tuser_next;
    logic                 m_tlast_reg,  m_tlast_next;

    // ------------------------------------------------------------------
    // Datapath nets
    // ------------------------------------------------------------------
    kind_t                kind;
    logic                 buf_full;
    logic                 buf_empty;
    logic                 out_free;
    logic                 last_entry;
    alu_req_t             alu_req;
    logic [ALU_W-1:0]     alu_sum;
    logic                 wr_en;
    logic [ENTRY_W-1:0]   wr_data;
    logic                 rd_en;
    logic [ENTRY_W-1:0]   rd_data;

    assign kind      = word_reg[KIND_LSB +: KIND_W];
    assign buf_full  = (fill_reg == FILL_W'(MAX_ENTRIES));
    assign buf_empty = (fill_reg == '0);
    // Output register can take a new entry when empty or draining this cycle.
    assign out_free  = !m_tvalid_reg || m_tready;
    // While emitting, the adder holds idx + 1; a match with the fill ends the block.
    assign last_entry = (alu_sum[FILL_W-1:0] == fill_reg);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // ------------------------------------------------------------------
    // Shared adder and entry buffer
    // ------------------------------------------------------------------
    aewd_alu u_alu (
        .req (alu_req),
        .sum (alu_sum)
    );

    aewd_store #(
        .DEPTH  (MAX_ENTRIES),
        .ADDR_W (ADDR_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (fill_reg[ADDR_W-1:0]),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (idx_reg[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                case (kind)
                    KIND_DATA:   state_next = buf_full ? S_IDLE : S_BUMP;
                    KIND_END:    state_next = buf_empty ? S_IDLE : S_READ;
                    default:     state_next = S_IDLE;
                endcase
            end
            S_BUMP: begin
                state_next = S_IDLE;
            end
            S_READ: begin
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    state_next = last_entry ? S_IDLE : S_READ;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: datapath controls and register updates
    // ------------------------------------------------------------------
    always_comb begin
        word_next     = word_reg;
        fill_next     = fill_reg;
        overflow_next = overflow_reg;
        idx_next      = idx_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        alu_req       = '0;
        wr_en         = 1'b0;
        wr_data       = {word_reg[CHAN_LSB +: CHAN_W], alu_sum};
        rd_en         = 1'b0;

        case (state_reg)
            S_IDLE: begin
                // Capture the word; it only counts once s_tvalid moves us on.
                word_next = s_tdata;
            end
            S_DECODE: begin
                case (kind)
                    KIND_HEADER: begin
                        // Open a new block: drop whatever was stored.
                        fill_next     = '0;
                        overflow_next = 1'b0;
                    end
                    KIND_DATA: begin
                        if (buf_full) begin
                            overflow_next = 1'b1;
                        end else begin
                            // Negate through the adder when the sign bit is set.
                            alu_req.operand = ALU_W'(word_reg[MAG_W-1:0]);
                            alu_req.invert  = word_reg[SIGN_POS];
                            alu_req.carry   = word_reg[SIGN_POS];
                            wr_en           = 1'b1;
                        end
                    end
                    KIND_END: begin
                        if (buf_empty) begin
                            overflow_next = 1'b0;
                        end else begin
                            idx_next = '0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_BUMP: begin
                // Advance the fill count behind the entry just written.
                alu_req.operand = ALU_W'(fill_reg);
                alu_req.carry   = 1'b1;
                fill_next       = alu_sum[FILL_W-1:0];
            end
            S_READ: begin
                rd_en = 1'b1;
            end
            S_EMIT: begin
                alu_req.operand = ALU_W'(idx_reg);
                alu_req.carry   = 1'b1;
                if (out_free) begin
                    m_tvalid_next                              = 1'b1;
                    m_tdata_next                               = '0;
                    m_tdata_next[CHAN_W-1:0]                   = rd_data[ENTRY_W-1 -: CHAN_W];
                    m_tdata_next[CHAN_W +: VALUE_W]            = rd_data[VALUE_W-1:0];
                    m_tdata_next[CHAN_W + VALUE_W +: COUNT_W]  = word_reg[COUNT_W-1:0];
                    m_tuser_next                               = overflow_reg;
                    m_tlast_next                               = last_entry;
                    idx_next                                   = alu_sum[FILL_W-1:0];
                    if (last_entry) begin
                        // Block drained: the next block starts empty.
                        fill_next     = '0;
                        overflow_next = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Register bank
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            fill_reg     <= '0;
            overflow_reg <= 1'b0;
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            overflow_reg <= overflow_next;
            idx_reg      <= idx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        word_reg    <= word_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `AEWD_CHECK(a_fill_bound, fill_reg <= FILL_W'(MAX_ENTRIES), "fill count beyond capacity")
    `AEWD_CHECK_NEXT(a_one_word, s_tvalid && s_tready, !s_tready, "second word taken while busy")
    `AEWD_CHECK_IMP(a_read_in_range, state_reg == S_READ, idx_reg < fill_reg, "read past fill")
    `AEWD_CHECK_NEXT(a_drain_clears, state_reg == S_EMIT && out_free && last_entry, fill_reg == '0 && !overflow_reg, "block not cleared after last entry")

endmodule

// File: rtl/aewd_alu.sv
// ----------------------------------------------------------------------------
// aewd_alu
// Shared adder: negates magnitudes and advances the fill and drain counters.
// ----------------------------------------------------------------------------
module aewd_alu
    import aewd_pkg::*;
(
    input  alu_req_t         req,
    output logic [ALU_W-1:0] sum
);

    logic [ALU_W-1:0] addend;

    assign addend = req.invert ? ~req.operand : req.operand;
    assign sum    = addend + ALU_W'(req.carry);

endmodule

// File: rtl/aewd_store.sv
// ----------------------------------------------------------------------------
// aewd_store
// Entry buffer: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module aewd_store
    import aewd_pkg::*;
#(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic               aclk,
    input  logic               wr_en,
    input  logic [ADDR_W-1:0]  wr_addr,
    input  logic [ENTRY_W-1:0] wr_data,
    input  logic               rd_en,
    input  logic [ADDR_W-1:0]  rd_addr,
    output logic [ENTRY_W-1:0] rd_data
);

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
